[rtl/fsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy fan speed controller package
// Field widths, membership breakpoints, register indexes and reset speeds.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int TEMP_BITS  = 10;
   localparam int HUM_BITS   = 11;
   localparam int FAN_BITS   = 11;
   localparam int SPEED_BITS = 7;
   localparam int FAN_MAX    = 2047;

   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_COLD_DRY      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_COLD_MODERATE = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_WARM_MODERATE = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_HOT_HUMID     = 4'd3;

   localparam logic [SPEED_BITS-1:0] RST_SPEED_COLD_DRY      = 7'd20;
   localparam logic [SPEED_BITS-1:0] RST_SPEED_COLD_MODERATE = 7'd40;
   localparam logic [SPEED_BITS-1:0] RST_SPEED_WARM_MODERATE = 7'd70;
   localparam logic [SPEED_BITS-1:0] RST_SPEED_HOT_HUMID     = 7'd100;

   // triangle breakpoints in whole degrees / percent
   localparam int TEMP_COLD_L = 18;
   localparam int TEMP_COLD_P = 22;
   localparam int TEMP_COLD_R = 24;
   localparam int TEMP_WARM_L = 22;
   localparam int TEMP_WARM_P = 24;
   localparam int TEMP_WARM_R = 28;
   localparam int TEMP_HOT_L  = 24;
   localparam int TEMP_HOT_P  = 28;
   localparam int TEMP_HOT_R  = 32;
   localparam int HUM_DRY_L   = 30;
   localparam int HUM_DRY_P   = 40;
   localparam int HUM_DRY_R   = 50;
   localparam int HUM_MOD_L   = 40;
   localparam int HUM_MOD_P   = 50;
   localparam int HUM_MOD_R   = 60;
   localparam int HUM_WET_L   = 50;
   localparam int HUM_WET_P   = 60;
   localparam int HUM_WET_R   = 70;

   typedef struct packed {
      logic [SPEED_BITS-1:0] cold_dry;
      logic [SPEED_BITS-1:0] cold_moderate;
      logic [SPEED_BITS-1:0] warm_moderate;
      logic [SPEED_BITS-1:0] hot_humid;
   } speeds_type;

endpackage
`default_nettype wire

[rtl/fsc_grade.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Triangular membership grading
// Three stages: side select, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module fsc_grade #(
   parameter int XW          = 10,
   parameter int L           = 18,
   parameter int P           = 22,
   parameter int R           = 24,
   parameter int WEIGHT_BITS = 8,
   parameter int FRAC_BITS   = 4
) (
   input  wire logic                 clock,
   input  wire logic [2:0]           load,
   input  wire logic [XW-1:0]        x_in,
   output logic      [WEIGHT_BITS:0] weight
);

   localparam logic [31:0] L_S  = 32'(L) << FRAC_BITS;
   localparam logic [31:0] P_S  = 32'(P) << FRAC_BITS;
   localparam logic [31:0] R_S  = 32'(R) << FRAC_BITS;
   localparam int          DL   = (P - L) << FRAC_BITS;
   localparam int          DR   = (R - P) << FRAC_BITS;
   localparam int          DMAX = (DL > DR) ? DL : DR;
   localparam int          NW   = $clog2(DMAX + 1);
   localparam int          AW   = NW + WEIGHT_BITS;
   localparam int          WTW  = WEIGHT_BITS + 1;
   localparam logic [AW-1:0] M_L = AW'((64'd1 << AW) / DL);
   localparam logic [AW-1:0] M_R = AW'((64'd1 << AW) / DR);
   localparam logic [NW-1:0] D_L = NW'(DL);
   localparam logic [NW-1:0] D_R = NW'(DR);

   // stage 0
   logic [31:0]    x_ext;
   logic [31:0]    diff;
   logic           rise;
   logic           fall;
   logic [NW-1:0]  n_in;
   logic [NW-1:0]  n_ff;
   logic           right_in;
   logic           right0_ff;
   logic           hit_in;
   logic           hit0_ff;

   // stage 1
   logic [AW-1:0]   a_in;
   logic [AW-1:0]   a_ff;
   logic [AW-1:0]   m_sel;
   logic [2*AW-1:0] prod;
   logic [WTW-1:0]  qe_in;
   logic [WTW-1:0]  qe_ff;
   logic            right1_ff;
   logic            hit1_ff;

   // stage 2
   logic [NW-1:0]  d_sel;
   logic [AW:0]    back;
   logic [AW:0]    rem;
   logic [WTW-1:0] weight_in;
   logic [WTW-1:0] weight_ff;

   always_comb begin
      x_ext    = 32'(x_in);
      rise     = (x_ext > L_S) && (x_ext <= P_S);
      fall     = (x_ext > P_S) && (x_ext < R_S);
      diff     = rise ? (x_ext - L_S) : (R_S - x_ext);
      n_in     = diff[NW-1:0];
      right_in = !rise;
      hit_in   = rise || fall;
   end

   always_comb begin
      a_in  = AW'(n_ff) << WEIGHT_BITS;
      m_sel = right0_ff ? M_R : M_L;
      prod  = (2*AW)'(a_in) * (2*AW)'(m_sel);
      // estimate is exact or one short
      qe_in = prod[AW +: WTW];
   end

   always_comb begin
      d_sel = right1_ff ? D_R : D_L;
      back  = (AW+1)'(qe_ff) * (AW+1)'(d_sel);
      rem   = (AW+1)'(a_ff) - back;
      if (!hit1_ff) begin
         weight_in = '0;
      end else if (rem >= (AW+1)'(d_sel)) begin
         weight_in = qe_ff + WTW'(1);
      end else begin
         weight_in = qe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         n_ff      <= n_in;
         right0_ff <= right_in;
         hit0_ff   <= hit_in;
      end
      if (load[1]) begin
         a_ff      <= a_in;
         qe_ff     <= qe_in;
         right1_ff <= right0_ff;
         hit1_ff   <= hit0_ff;
      end
      if (load[2]) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule
`default_nettype wire

[rtl/fsc_rules.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Rule evaluation
// Rule strengths by minimum, weighted speeds and total weight over three stages.
// ----------------------------------------------------------------------------
module fsc_rules #(
   parameter int WEIGHT_BITS = 8,
   parameter int FRAC_BITS   = 4
) (
   input  wire logic                           clock,
   input  wire logic [2:0]                     load,
   input  wire logic [WEIGHT_BITS:0]           w_cold,
   input  wire logic [WEIGHT_BITS:0]           w_warm,
   input  wire logic [WEIGHT_BITS:0]           w_hot,
   input  wire logic [WEIGHT_BITS:0]           w_dry,
   input  wire logic [WEIGHT_BITS:0]           w_mod,
   input  wire logic [WEIGHT_BITS:0]           w_wet,
   input  wire fsc_pkg::speeds_type            speeds,
   output logic [WEIGHT_BITS+9+FRAC_BITS:0]    dividend,
   output logic [WEIGHT_BITS+2:0]              total
);

   localparam int WTW  = WEIGHT_BITS + 1;
   localparam int TOTW = WEIGHT_BITS + 3;
   localparam int PW   = WTW + fsc_pkg::SPEED_BITS;
   localparam int NUMW = TOTW + fsc_pkg::SPEED_BITS;
   localparam int DVW  = NUMW + FRAC_BITS;

   logic [WTW-1:0]                  rule_in [4];
   logic [WTW-1:0]                  rule_ff [4];
   logic [fsc_pkg::SPEED_BITS-1:0]  spd     [4];
   logic [PW-1:0]                   prod_in [4];
   logic [PW-1:0]                   prod_ff [4];
   logic [TOTW-1:0]                 total_in;
   logic [TOTW-1:0]                 total4_ff;
   logic [TOTW-1:0]                 total5_ff;
   logic [NUMW-1:0]                 num;
   logic [DVW-1:0]                  dividend_in;
   logic [DVW-1:0]                  dividend_ff;

   always_comb begin
      rule_in[0] = (w_cold < w_dry) ? w_cold : w_dry;
      rule_in[1] = (w_cold < w_mod) ? w_cold : w_mod;
      rule_in[2] = (w_warm < w_mod) ? w_warm : w_mod;
      rule_in[3] = (w_hot  < w_wet) ? w_hot  : w_wet;
   end

   assign spd[0] = speeds.cold_dry;
   assign spd[1] = speeds.cold_moderate;
   assign spd[2] = speeds.warm_moderate;
   assign spd[3] = speeds.hot_humid;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = PW'(rule_ff[i]) * PW'(spd[i]);
      end
      total_in = TOTW'(rule_ff[0]) + TOTW'(rule_ff[1])
               + TOTW'(rule_ff[2]) + TOTW'(rule_ff[3]);
   end

   always_comb begin
      num = NUMW'(prod_ff[0]) + NUMW'(prod_ff[1])
          + NUMW'(prod_ff[2]) + NUMW'(prod_ff[3]);
      dividend_in = DVW'(num) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rule_ff <= rule_in;
      end
      if (load[1]) begin
         prod_ff   <= prod_in;
         total4_ff <= total_in;
      end
      if (load[2]) begin
         dividend_ff <= dividend_in;
         total5_ff   <= total4_ff;
      end
   end

   assign dividend = dividend_ff;
   assign total    = total5_ff;

endmodule
`default_nettype wire

[rtl/fsc_div_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Divider step
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fsc_div_step #(
   parameter int DW = 11,
   parameter int QW = 11
) (
   input  wire logic             clock,
   input  wire logic             load,
   input  wire logic [DW+QW-1:0] acc_in,
   input  wire logic [DW-1:0]    div_in,
   output logic      [DW+QW-1:0] acc_out,
   output logic      [DW-1:0]    div_out
);

   logic [DW:0]       top;
   logic [DW:0]       trial;
   logic [DW+QW-1:0]  acc_in_next;
   logic [DW+QW-1:0]  acc_ff;
   logic [DW-1:0]     div_ff;

   // upper bits hold the partial remainder, lower bits collect quotient bits
   always_comb begin
      top   = acc_in[DW+QW-1:QW-1];
      trial = top - (DW+1)'(div_in);
      if (top >= (DW+1)'(div_in)) begin
         acc_in_next = {trial[DW-1:0], acc_in[QW-2:0], 1'b1};
      end else begin
         acc_in_next = {acc_in[DW+QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= acc_in_next;
         div_ff <= div_in;
      end
   end

   assign acc_out = acc_ff;
   assign div_out = div_ff;

endmodule
`default_nettype wire

[rtl/fuzzy_fan_speed_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy fan speed controller
// Sugeno inference over temperature and humidity, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  temperature, humidity
//  rsp_      out        rsp_valid / rsp_stall  duty, recommended
//  csr_      in         csr_valid / csr_ready  index, data (rule speed)
//
//  One transaction per cycle unless the pipeline is full and the output stalled.
//  The pipeline holds three grading stages, three rule stages, one divider stage
//  per quotient bit and the output register.
//  Reset clears every stage valid and loads the rule speeds 20, 40, 70, 100.
//  A stalled result holds; empty stages behind it keep filling.
// ----------------------------------------------------------------------------
module fuzzy_fan_speed_controller #(
   parameter int WEIGHT_BITS     = 8,
   parameter int INPUT_FRAC_BITS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [fsc_pkg::TEMP_BITS-1:0]       req_temperature,
   input  wire logic [fsc_pkg::HUM_BITS-1:0]        req_humidity,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [fsc_pkg::FAN_BITS-1:0]        rsp_duty,
   output logic                                     rsp_recommended,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [fsc_pkg::SPEED_BITS-1:0]      csr_data
);

   localparam int WTW    = WEIGHT_BITS + 1;
   localparam int TOTW   = WEIGHT_BITS + 3;
   localparam int QW     = fsc_pkg::SPEED_BITS + INPUT_FRAC_BITS;
   localparam int DVW    = TOTW + QW;
   localparam int NSTAGE = 7 + QW;
   localparam int OXW    = (QW > fsc_pkg::FAN_BITS) ? QW : fsc_pkg::FAN_BITS;

   fsc_pkg::speeds_type speeds_ff;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] load;

   logic [WTW-1:0] w_cold;
   logic [WTW-1:0] w_warm;
   logic [WTW-1:0] w_hot;
   logic [WTW-1:0] w_dry;
   logic [WTW-1:0] w_mod;
   logic [WTW-1:0] w_wet;

   logic [DVW-1:0]  acc [0:QW];
   logic [TOTW-1:0] dv  [0:QW];

   logic [OXW-1:0]                 q_wide;
   logic [fsc_pkg::FAN_BITS-1:0]   fan_in;
   logic                           rec_in;
   logic [fsc_pkg::FAN_BITS-1:0]   rsp_duty_ff;
   logic                           rsp_recommended_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speeds_ff.cold_dry      <= fsc_pkg::RST_SPEED_COLD_DRY;
         speeds_ff.cold_moderate <= fsc_pkg::RST_SPEED_COLD_MODERATE;
         speeds_ff.warm_moderate <= fsc_pkg::RST_SPEED_WARM_MODERATE;
         speeds_ff.hot_humid     <= fsc_pkg::RST_SPEED_HOT_HUMID;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fsc_pkg::CSR_SPEED_COLD_DRY:      speeds_ff.cold_dry      <= csr_data;
            fsc_pkg::CSR_SPEED_COLD_MODERATE: speeds_ff.cold_moderate <= csr_data;
            fsc_pkg::CSR_SPEED_WARM_MODERATE: speeds_ff.warm_moderate <= csr_data;
            fsc_pkg::CSR_SPEED_HOT_HUMID:     speeds_ff.hot_humid     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // a stage may load unless it and every stage after it are full and the output is stalled
   for (genvar k = 0; k < NSTAGE; k++) begin : g_load
      assign load[k] = ~((&valid_ff[NSTAGE-1:k]) & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   // membership grading, stages 0 to 2
   fsc_grade #(
      .XW(fsc_pkg::TEMP_BITS), .L(fsc_pkg::TEMP_COLD_L), .P(fsc_pkg::TEMP_COLD_P),
      .R(fsc_pkg::TEMP_COLD_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_cold (.clock(clock), .load(load[2:0]), .x_in(req_temperature), .weight(w_cold));

   fsc_grade #(
      .XW(fsc_pkg::TEMP_BITS), .L(fsc_pkg::TEMP_WARM_L), .P(fsc_pkg::TEMP_WARM_P),
      .R(fsc_pkg::TEMP_WARM_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_warm (.clock(clock), .load(load[2:0]), .x_in(req_temperature), .weight(w_warm));

   fsc_grade #(
      .XW(fsc_pkg::TEMP_BITS), .L(fsc_pkg::TEMP_HOT_L), .P(fsc_pkg::TEMP_HOT_P),
      .R(fsc_pkg::TEMP_HOT_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_hot (.clock(clock), .load(load[2:0]), .x_in(req_temperature), .weight(w_hot));

   fsc_grade #(
      .XW(fsc_pkg::HUM_BITS), .L(fsc_pkg::HUM_DRY_L), .P(fsc_pkg::HUM_DRY_P),
      .R(fsc_pkg::HUM_DRY_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_dry (.clock(clock), .load(load[2:0]), .x_in(req_humidity), .weight(w_dry));

   fsc_grade #(
      .XW(fsc_pkg::HUM_BITS), .L(fsc_pkg::HUM_MOD_L), .P(fsc_pkg::HUM_MOD_P),
      .R(fsc_pkg::HUM_MOD_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_mod (.clock(clock), .load(load[2:0]), .x_in(req_humidity), .weight(w_mod));

   fsc_grade #(
      .XW(fsc_pkg::HUM_BITS), .L(fsc_pkg::HUM_WET_L), .P(fsc_pkg::HUM_WET_P),
      .R(fsc_pkg::HUM_WET_R), .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_wet (.clock(clock), .load(load[2:0]), .x_in(req_humidity), .weight(w_wet));

   // rules, stages 3 to 5
   fsc_rules #(
      .WEIGHT_BITS(WEIGHT_BITS), .FRAC_BITS(INPUT_FRAC_BITS)
   ) u_rules (
      .clock    (clock),
      .load     (load[5:3]),
      .w_cold   (w_cold),
      .w_warm   (w_warm),
      .w_hot    (w_hot),
      .w_dry    (w_dry),
      .w_mod    (w_mod),
      .w_wet    (w_wet),
      .speeds   (speeds_ff),
      .dividend (acc[0]),
      .total    (dv[0])
   );

   // divider, one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_div
      fsc_div_step #(.DW(TOTW), .QW(QW)) u_step (
         .clock   (clock),
         .load    (load[6+i]),
         .acc_in  (acc[i]),
         .div_in  (dv[i]),
         .acc_out (acc[i+1]),
         .div_out (dv[i+1])
      );
   end

   // output stage: zero weight gives no recommendation, else saturate
   always_comb begin
      q_wide = OXW'(acc[QW][QW-1:0]);
      rec_in = (dv[QW] != '0);
      if (!rec_in) begin
         fan_in = '0;
      end else if (q_wide > OXW'(fsc_pkg::FAN_MAX)) begin
         fan_in = fsc_pkg::FAN_BITS'(fsc_pkg::FAN_MAX);
      end else begin
         fan_in = q_wide[fsc_pkg::FAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[NSTAGE-1]) begin
         rsp_duty_ff        <= fan_in;
         rsp_recommended_ff <= rec_in;
      end
   end

   assign rsp_duty        = rsp_duty_ff;
   assign rsp_recommended = rsp_recommended_ff;

endmodule
`default_nettype wire

[rtl/fsc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy fan speed controller checker
// Port level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [fsc_pkg::FAN_BITS-1:0]  rsp_duty,
   input wire logic                          rsp_recommended
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty)
                                 && $stable(rsp_recommended))
      else $error("stalled result changed");

   // no rule fired means no speed
   a_no_rec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_recommended |-> rsp_duty == '0)
      else $error("speed given without recommendation");

   // input back-pressure only comes from a full pipeline behind a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // grading and rule stages alone keep the output empty for a while after reset
   a_latency: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid [*6])
      else $error("result appeared without latency");

endmodule

bind fuzzy_fan_speed_controller fsc_checker u_fsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_duty        (rsp_duty),
   .rsp_recommended (rsp_recommended)
);
`default_nettype wire
